@@ hdl/grid_bfs_next_step_core_assert.svh @@
// assertion macros for the grid next-step core
`ifndef GRID_BFS_NEXT_STEP_CORE_ASSERT_SVH
`define GRID_BFS_NEXT_STEP_CORE_ASSERT_SVH
`define GB_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m failed");
`define GB_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m failed");
`endif

@@ hdl/gbns_pkg.sv @@
// ----------------------------------------------------------------------------
// gbns_pkg
// shared constants, types and direction tables
// ----------------------------------------------------------------------------
package gbns_pkg;
  localparam int MaxColumns = 64;
  localparam int MaxRows    = 64;
  localparam int CellCount  = 4096;
  localparam int CellW      = 12;
  localparam int CfgW       = 7;
  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;
  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef struct packed {
    logic valid;
    logic found;
  } status_t;

  function automatic logic signed [1:0] step_row(input logic [2:0] k);
    case (k)
      3'd2, 3'd4, 3'd5: step_row = -2'sd1;
      3'd3, 3'd6, 3'd7: step_row = 2'sd1;
      default:          step_row = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] step_col(input logic [2:0] k);
    case (k)
      3'd0, 3'd4, 3'd6: step_col = -2'sd1;
      3'd1, 3'd5, 3'd7: step_col = 2'sd1;
      default:          step_col = 2'sd0;
    endcase
  endfunction
endpackage

@@ hdl/gbns_ram.sv @@
// ----------------------------------------------------------------------------
// gbns_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module gbns_ram #(
  parameter int Width = 1,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ hdl/grid_bfs_next_step_core.sv @@
// ----------------------------------------------------------------------------
// grid_bfs_next_step_core
// 8-connected breadth-first next-step finder over a loaded passable grid.
// A query first sweeps the distance memory, one cell per cycle, then floods
// from the target on the single shared neighbour/compare unit and
// single-port memories: each dequeued cell's index is split into row and
// column by repeated subtraction, then its eight neighbour directions are
// tried in turn, those off the grid being skipped. Once the source is
// dequeued its eight neighbours are scanned for the smallest distance.
// After reset the passable memory is cleared, one cell per cycle, with
// busy high. The result shows on next_cell/found for one cycle with done
// high; it cannot be stalled.
// ----------------------------------------------------------------------------
module grid_bfs_next_step_core #(
  parameter int MAX_COLUMNS = gbns_pkg::MaxColumns,
  parameter int MAX_ROWS    = gbns_pkg::MaxRows,
  parameter int CELL_COUNT  = gbns_pkg::CellCount
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      mode,
  input  logic [gbns_pkg::CellW-1:0] cell_req,
  input  logic                      passable,
  input  logic [gbns_pkg::CellW-1:0] source_cell,
  input  logic [gbns_pkg::CellW-1:0] target_cell,
  output logic                      done,
  output logic [gbns_pkg::CellW-1:0] next_cell,
  output logic                      found,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [0:0]                cfg_index,
  input  logic [gbns_pkg::CfgW-1:0] cfg_data
);
  localparam int AW = $clog2(CELL_COUNT);
  localparam int DW = AW + 1;
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int QW = AW + 1;
  localparam logic [DW-1:0] Unreached = '1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOAD, S_DCLR, S_CHK, S_DEQ, S_POP,
    S_NB, S_NBR, S_NBW, S_NBD, S_FIN, S_FINR, S_FINW, S_FIND, S_OUT
  } state_t;

  state_t state;
  logic [gbns_pkg::CfgW-1:0] reg_w, reg_h;
  logic [CW-1:0] w;
  logic [RW-1:0] h;
  logic [AW:0]   size;
  logic [AW-1:0] src, tgt, cur, nb, best, sweep;
  logic [DW-1:0] cur_d, min_d;
  logic [2:0]    k;
  logic [QW-1:0] head, tail;
  logic [RW-1:0] cur_r, r_ctr;
  logic [CW-1:0] cur_c;
  logic          nb_ok;
  logic          res_found;
  gbns_pkg::status_t st;

  // passable memory
  logic          p_we, p_wd, p_rd;
  logic [AW-1:0] p_addr;
  // distance memory
  logic          d_we;
  logic [AW-1:0] d_addr;
  logic [DW-1:0] d_wd, d_rd;
  // queue memory
  logic          q_we;
  logic [AW-1:0] q_addr, q_wd, q_rd;

  gbns_ram #(.Width(1),  .Depth(CELL_COUNT)) u_pass
    (.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd));
  gbns_ram #(.Width(DW), .Depth(CELL_COUNT)) u_dist
    (.clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wd), .rdata(d_rd));
  gbns_ram #(.Width(AW), .Depth(CELL_COUNT)) u_queue
    (.clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wd), .rdata(q_rd));

  // clamp configuration
  logic [CW-1:0] w_cl;
  logic [RW-1:0] h_cl;
  logic [AW:0]   h_lim;
  always_comb begin
    if (reg_w == '0) w_cl = CW'(1);
    else if (32'(reg_w) > MAX_COLUMNS) w_cl = CW'(MAX_COLUMNS);
    else w_cl = CW'(reg_w);
    h_lim = (AW+1)'(CELL_COUNT) / (AW+1)'(1);
    if (reg_h == '0) h_cl = RW'(1);
    else if (32'(reg_h) > MAX_ROWS) h_cl = RW'(MAX_ROWS);
    else h_cl = RW'(reg_h);
  end

  // shared neighbour unit: row/col of current cell and offset by direction
  logic signed [RW+1:0] nr;
  logic signed [CW+1:0] nc;
  always_comb begin
    nr = $signed({2'b00, cur_r}) + (RW+2)'(gbns_pkg::step_row(k));
    nc = $signed({2'b00, cur_c}) + (CW+2)'(gbns_pkg::step_col(k));
    nb_ok = (nr >= 0) && (nc >= 0) && (nr < $signed({2'b00, h}))
            && (nc < $signed({2'b00, w}));
  end

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign st        = '{valid: (state == S_OUT), found: res_found};
  assign done      = st.valid;
  assign found     = st.found;
  assign next_cell = gbns_pkg::CellW'(best);

  always_comb begin
    p_we = 1'b0; p_wd = 1'b0; p_addr = nb;
    d_we = 1'b0; d_wd = Unreached; d_addr = nb;
    q_we = 1'b0; q_wd = nb; q_addr = tail[AW-1:0];
    case (state)
      S_CLR:  begin p_we = 1'b1; p_addr = sweep; end
      S_IDLE: begin
        if (start && mode == gbns_pkg::ModeLoad && 32'(cell_req) < CELL_COUNT) begin
          p_we = 1'b1; p_addr = AW'(cell_req); p_wd = passable;
        end
      end
      S_DCLR: begin d_we = 1'b1; d_addr = sweep; end
      S_CHK:  begin d_we = 1'b1; d_addr = tgt; d_wd = '0;
                    q_we = 1'b1; q_addr = '0; q_wd = tgt; end
      S_DEQ:  begin q_addr = head[AW-1:0]; end
      S_POP:  begin d_addr = q_rd; end
      S_NB:   begin d_addr = cur; end
      S_NBD:  begin
        if (d_rd == Unreached && (nb == src || p_rd) && tail < QW'(CELL_COUNT)) begin
          d_we = 1'b1; d_wd = cur_d + DW'(1); q_we = 1'b1;
        end
      end
      S_FIN, S_FINW: begin d_addr = src; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      sweep <= '0;
      reg_w <= gbns_pkg::CfgW'(64);
      reg_h <= gbns_pkg::CfgW'(64);
      res_found <= 1'b0;
      head <= '0;
      tail <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gbns_pkg::RegWidth) reg_w <= cfg_data;
        else reg_h <= cfg_data;
      end
      case (state)
        S_CLR: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(CELL_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            if (mode == gbns_pkg::ModeLoad) begin
              state <= (32'(cell_req) < CELL_COUNT) ? S_LOAD : S_IDLE;
            end else begin
              src <= AW'(source_cell);
              tgt <= AW'(target_cell);
              w <= w_cl;
              h <= h_cl;
              r_ctr <= '0;
              size <= '0;
              sweep <= '0;
              best <= '0;
              res_found <= 1'b0;
              state <= S_DCLR;
              if (32'(source_cell) >= CELL_COUNT || 32'(target_cell) >= CELL_COUNT)
                src <= AW'(target_cell);
            end
          end
        end
        S_LOAD: state <= S_IDLE;
        S_DCLR: begin
          // accumulate size = w*h one row per cycle, capped to cell count
          if (r_ctr < h && (size + (AW+1)'(w)) <= (AW+1)'(CELL_COUNT)) begin
            size <= size + (AW+1)'(w);
            r_ctr <= r_ctr + RW'(1);
          end
          sweep <= sweep + AW'(1);
          if (sweep == AW'(CELL_COUNT - 1)) begin
            h <= r_ctr;
            head <= '0;
            tail <= QW'(1);
            state <= S_CHK;
            if (src == tgt || (AW+1)'(src) >= size || (AW+1)'(tgt) >= size ||
                h_lim == '0)
              state <= S_OUT;
          end
        end
        S_CHK: state <= S_DEQ;
        S_DEQ: begin
          if (head >= tail) state <= S_OUT;
          else begin
            head <= head + QW'(1);
            state <= S_POP;
          end
        end
        S_POP: begin
          cur <= q_rd;
          // split index into row and column by stepping rows
          cur_r <= '0;
          cur_c <= '0;
          sweep <= q_rd;
          state <= S_NB;
          k <= 3'd7;
          if (q_rd == src) begin
            res_found <= 1'b1;
            state <= S_FIN;
          end
        end
        S_NB: begin
          // row/col split, one row subtraction per cycle
          if (sweep >= AW'(w)) begin
            sweep <= sweep - AW'(w);
            cur_r <= cur_r + RW'(1);
          end else begin
            cur_c <= CW'(sweep);
            cur_d <= d_rd;
            k <= 3'd0;
            state <= S_NBR;
          end
        end
        S_NBR: begin
          if (nb_ok) begin
            nb <= AW'(AW'(nr) * AW'(w) + AW'(nc));
            state <= S_NBW;
          end else if (k == 3'd7) state <= S_DEQ;
          else k <= k + 3'd1;
        end
        S_NBW: state <= S_NBD;
        S_NBD: begin
          if (d_rd == Unreached && (nb == src || p_rd) && tail < QW'(CELL_COUNT))
            tail <= tail + QW'(1);
          if (k == 3'd7) state <= S_DEQ;
          else begin
            k <= k + 3'd1;
            state <= S_NBR;
          end
        end
        S_FIN: begin
          sweep <= src;
          cur_r <= '0;
          state <= S_FINW;
          k <= 3'd0;
        end
        S_FINW: begin
          if (sweep >= AW'(w)) begin
            sweep <= sweep - AW'(w);
            cur_r <= cur_r + RW'(1);
          end else begin
            cur_c <= CW'(sweep);
            min_d <= d_rd;
            best <= src;
            state <= S_FINR;
          end
        end
        S_FINR: begin
          if (nb_ok) begin
            nb <= AW'(AW'(nr) * AW'(w) + AW'(nc));
            state <= S_FIND;
            sweep <= '0;
          end else if (k == 3'd7) state <= S_OUT;
          else k <= k + 3'd1;
        end
        S_FIND: begin
          // registered read: the address is presented first, then the returned distance is compared
          if (sweep == '0) sweep <= AW'(1);
          else begin
            if (d_rd < min_d) begin
              min_d <= d_rd;
              best <= nb;
            end
            if (k == 3'd7) state <= S_OUT;
            else begin
              k <= k + 3'd1;
              state <= S_FINR;
            end
          end
        end
        S_OUT: begin
          if (!res_found) best <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/gbns_checker.sv @@
// ----------------------------------------------------------------------------
// gbns_checker
// port-level checks on the next-step core
// ----------------------------------------------------------------------------
`include "grid_bfs_next_step_core_assert.svh"
module gbns_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done,
  input logic found,
  input logic [11:0] next_cell
);
  `GB_ASSERT_IMP(a_done_busy, done, busy)
  `GB_ASSERT_NXT(a_done_single, done, !done)
  `GB_ASSERT_IMP(a_nofound_zero, done && !found, next_cell == 12'd0)
  `GB_ASSERT_NXT(a_done_idle, done, !busy)
endmodule

bind grid_bfs_next_step_core gbns_checker u_gbns_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done),
  .found(found), .next_cell(next_cell)
);

@@ tb/grid_bfs_next_step_checker.sv @@
// ----------------------------------------------------------------------------
// grid_bfs_next_step_checker
// Watches the command, configuration and result ports of the next-step core.
// It keeps its own passable map and grid size and floods breadth-first from
// the target for every accepted query. Each result beat is compared with the
// oldest predicted step.
// ----------------------------------------------------------------------------
module grid_bfs_next_step_checker
  import gbns_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              mode,
  input  logic [CellW-1:0]  cell_req,
  input  logic              passable,
  input  logic [CellW-1:0]  source_cell,
  input  logic [CellW-1:0]  target_cell,
  input  logic              done,
  input  logic [CellW-1:0]  next_cell,
  input  logic              found,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [CfgW-1:0]   cfg_data,
  output int                fail_count,
  output int                pending,
  output int                found_count
);
  localparam int Unreached = 32'h7fffffff;

  typedef struct packed {
    logic [CellW-1:0] next_cell;
    logic             found;
  } step_t;

  const int row_step[8] = '{0, 0, -1, 1, -1, -1, 1, 1};
  const int col_step[8] = '{-1, 1, 0, 0, -1, 1, -1, 1};

  logic [CfgW-1:0] width_reg, height_reg;
  bit   pass_map[CellCount];
  int   dist_map[CellCount];
  int   frontier[CellCount];
  step_t expected_steps[$];

  function automatic bit neighbour(input int c, input int k, input int w, input int h,
                                   output int n);
    int r, col;
    r = c / w + row_step[k];
    col = c % w + col_step[k];
    n = r * w + col;
    return !(r < 0 || col < 0 || r >= h || col >= w);
  endfunction

  function automatic step_t next_step_of(input int src, input int tgt);
    step_t res;
    int w, h, head, tail, c, n, best, min_d;
    bit hit;
    res = '0;
    hit = 0;
    w = (width_reg < 1) ? 1 : (width_reg > MaxColumns) ? MaxColumns : width_reg;
    h = (height_reg < 1) ? 1 : (height_reg > MaxRows) ? MaxRows : height_reg;
    if (h > CellCount / w) h = CellCount / w;
    for (int i = 0; i < CellCount; i++) dist_map[i] = Unreached;
    if (src == tgt || src >= w * h || tgt >= w * h) return res;
    head = 0;
    tail = 1;
    frontier[0] = tgt;
    dist_map[tgt] = 0;
    while (head < tail) begin
      c = frontier[head];
      head++;
      if (c == src) begin
        hit = 1;
        break;
      end
      for (int k = 0; k < 8; k++) begin
        if (!neighbour(c, k, w, h, n)) continue;
        if (dist_map[n] != Unreached) continue;
        if (n != src && !pass_map[n]) continue;
        if (tail >= CellCount) continue;
        dist_map[n] = dist_map[c] + 1;
        frontier[tail] = n;
        tail++;
      end
    end
    if (!hit) return res;
    min_d = dist_map[src];
    best = src;
    for (int k = 0; k < 8; k++) begin
      if (neighbour(src, k, w, h, n) && dist_map[n] < min_d) begin
        min_d = dist_map[n];
        best = n;
      end
    end
    res.next_cell = best[CellW-1:0];
    res.found = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    step_t want;
    if (rst) begin
      width_reg <= CfgW'(MaxColumns);
      height_reg <= CfgW'(MaxRows);
      for (int i = 0; i < CellCount; i++) pass_map[i] = 0;
      expected_steps.delete();
      fail_count <= 0;
      pending <= 0;
      found_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegWidth) width_reg <= cfg_data;
        else width_reg <= width_reg;
        if (cfg_index == RegHeight) height_reg <= cfg_data;
      end
      if (done) begin
        if (expected_steps.size() == 0) begin
          $display("%0t: unexpected result next_cell=%0d found=%0b", $time, next_cell, found);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_steps.pop_front();
          if (want.found) found_count <= found_count + 1;
          if (want.found !== found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, found);
            fail_count <= fail_count + 1;
          end else if (want.next_cell !== next_cell) begin
            $display("%0t: next_cell expected %0d actual %0d", $time, want.next_cell,
                     next_cell);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (mode == ModeLoad) pass_map[cell_req] = passable;
        else expected_steps = {expected_steps, next_step_of(source_cell, target_cell)};
      end
      pending <= expected_steps.size();
    end
  end
endmodule

@@ tb/tb_grid_bfs_next_step_core.sv @@
// ----------------------------------------------------------------------------
// tb_grid_bfs_next_step_core
// Regression for the grid next-step core: directed loads and queries on the
// reset grid and an 8x8 grid, then random maps and queries over a range of
// grid sizes, edge sizes among them, with random gaps. The checker module
// predicts and compares.
module tb_grid_bfs_next_step_core;
  import gbns_pkg::*;

  localparam int CycleLimit = 4000000;

  logic             clk = 0;
  logic             rst = 1;
  logic             start = 0;
  logic             busy;
  logic             mode = ModeLoad;
  logic [CellW-1:0] cell_req = '0;
  logic             passable = 0;
  logic [CellW-1:0] source_cell = '0;
  logic [CellW-1:0] target_cell = '0;
  logic             done;
  logic [CellW-1:0] next_cell;
  logic             found;
  logic             cfg_valid = 0;
  logic             cfg_ready;
  logic [0:0]       cfg_index = RegWidth;
  logic [CfgW-1:0]  cfg_data = '0;
  int               fail_count, pending, found_count;
  int               cycles = 0;
  int               loads = 0, queries = 0;
  int               cur_w, cur_h;

  always #4 clk = ~clk;

  grid_bfs_next_step_core uut (.*);

  grid_bfs_next_step_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("grid_bfs_next_step_core regression: fail");
      $finish;
    end
  end

  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
    if (n > 0) begin
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(input logic m, input int a, input bit p, input int s, input int t);
    mode <= m;
    cell_req <= a[CellW-1:0];
    passable <= p;
    source_cell <= s[CellW-1:0];
    target_cell <= t[CellW-1:0];
    start <= 1;
    do @(posedge clk); while (busy);
    if (m == ModeLoad) loads++;
    else queries++;
    gap();
  endtask

  task automatic settle();
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input int val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[CfgW-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic resize(input int w, input int h);
    settle();
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    @(posedge clk);
    cur_w = (w < 1) ? 1 : (w > MaxColumns) ? MaxColumns : w;
    cur_h = (h < 1) ? 1 : (h > MaxRows) ? MaxRows : h;
  endtask

  int dims[7][2] = '{'{0, 0}, '{127, 127}, '{1, 64}, '{64, 1}, '{5, 7}, '{8, 8}, '{3, 4}};

  initial begin
    int size;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    while (busy) @(posedge clk);
    // reset grid: everything impassable
    issue(ModeQuery, 0, 0, 1, 0);
    issue(ModeQuery, 0, 0, 65, 0);
    issue(ModeQuery, 0, 0, 4095, 0);
    issue(ModeQuery, 0, 0, 7, 7);
    issue(ModeLoad, 4095, 1, 0, 0);
    issue(ModeLoad, 4094, 1, 0, 0);
    issue(ModeQuery, 0, 0, 4093, 4095);
    issue(ModeLoad, 4095, 0, 0, 0);
    issue(ModeQuery, 0, 0, 4093, 4095);
    resize(8, 8);
    // short corridor with a diagonal tie
    issue(ModeLoad, 9, 1, 0, 0);
    issue(ModeLoad, 10, 1, 0, 0);
    issue(ModeLoad, 18, 1, 0, 0);
    issue(ModeLoad, 7, 1, 0, 0);
    issue(ModeQuery, 0, 0, 0, 18);
    issue(ModeQuery, 0, 0, 7, 8);
    issue(ModeQuery, 0, 0, 100, 9);
    issue(ModeQuery, 0, 0, 9, 64);
    issue(ModeQuery, 0, 0, 63, 0);
    issue(ModeQuery, 0, 0, 18, 18);
    for (int ph = 0; ph < 7; ph++) begin
      resize(dims[ph][0], dims[ph][1]);
      size = cur_w * cur_h;
      for (int i = 0; i < 12; i++) begin
        case ($urandom_range(0, 9))
          0: issue(ModeLoad, $urandom_range(0, 4095), $urandom_range(0, 1), 0, 0);
          1: issue(ModeQuery, 0, 0, $urandom_range(0, 4095), $urandom_range(0, 4095));
          2, 3, 4: issue(ModeLoad, $urandom_range(0, size - 1),
                         (size > 64) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) < 7),
                         $urandom_range(0, 4095), $urandom_range(0, 4095));
          default: issue(ModeQuery, $urandom_range(0, 4095), $urandom_range(0, 1),
                         $urandom_range(0, size - 1), $urandom_range(0, size - 1));
        endcase
      end
    end
    settle();
    $display("ran %0d loads and %0d queries over %0d random grid sizes, %0d paths found",
             loads, queries, 7, found_count);
    if (fail_count == 0) begin
      $display("grid_bfs_next_step_core regression: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("grid_bfs_next_step_core regression: fail");
    end
    $finish;
  end
endmodule
